@@ hdl/cft_pkg.sv @@
package cft_pkg;

  typedef struct packed {
    logic               first_of_set;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        radius;
    logic [15:0]        color_r_in;
    logic [15:0]        color_g_in;
    logic [15:0]        color_b_in;
  } in_item_t;

  typedef struct packed {
    logic               is_triangle;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [15:0]        out_red;
    logic [15:0]        out_green;
    logic [15:0]        out_blue;
    logic [31:0]        index_a;
    logic [31:0]        index_b;
    logic [31:0]        index_c;
    logic               last_of_run;
  } out_item_t;

  // one point as the back end sees it: first_of_set already folded into base
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        radius;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [31:0]        base;
  } point_t;

  localparam int Q_DEPTH   = 2;
  localparam int OUT_DEPTH = 8;
  localparam int TRIG_W    = 17;  // Q1.16 magnitude, 0 .. 65536

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint signed   ONE_Q30     = 64'sd1073741824;

  localparam longint unsigned SIN_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
  localparam longint unsigned COS_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  function automatic logic [TRIG_W-1:0] q30_to_q16(longint signed v);
    longint unsigned u;
    if (v < 0) begin
      u = 0;
    end else begin
      u = (longint'(v) + 64'd8192) >> 14;
    end
    if (u > 64'd65536) begin
      u = 64'd65536;
    end
    return u[TRIG_W-1:0];
  endfunction

  // elaboration-time Taylor series, Q2.30, each product truncated
  function automatic logic [TRIG_W-1:0] trig_sin(longint unsigned x);
    longint unsigned t;
    longint signed   s;
    t = x;
    s = longint'(x);
    for (int n = 0; n < 8; n++) begin
      t = (t * x) >> 30;
      t = ((t * x) >> 30) / SIN_DIV[n];
      if (n[0] == 1'b0) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    return q30_to_q16(s);
  endfunction

  function automatic logic [TRIG_W-1:0] trig_cos(longint unsigned x);
    longint unsigned t;
    longint signed   c;
    t = longint'(ONE_Q30);
    c = ONE_Q30;
    for (int n = 0; n < 8; n++) begin
      t = (t * x) >> 30;
      t = ((t * x) >> 30) / COS_DIV[n];
      if (n[0] == 1'b0) begin
        c = c - longint'(t);
      end else begin
        c = c + longint'(t);
      end
    end
    return q30_to_q16(c);
  endfunction

endpackage

@@ hdl/cft_fifo.sv @@
module cft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH-1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             wr_ok, rd_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = data_r[rd_ptr_r];
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (wr_ok && !rd_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_ok && !wr_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      data_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/cft_front.sv @@
module cft_front import cft_pkg::*; #(
  parameter int SEGMENTS = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output point_t   q_data
);

  logic [31:0] base_r, base_nxt;
  logic [31:0] base_use;
  logic        accept;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign q_push   = accept;
  assign base_use = in_data.first_of_set ? 32'd0 : base_r;

  always_comb begin
    base_nxt = base_r;
    if (accept) begin
      base_nxt = base_use + 32'(SEGMENTS + 1);
    end
  end

  always_comb begin
    q_data.pos_x  = in_data.pos_x;
    q_data.pos_y  = in_data.pos_y;
    q_data.radius = in_data.radius;
    q_data.red    = in_data.color_r_in;
    q_data.green  = in_data.color_g_in;
    q_data.blue   = in_data.color_b_in;
    q_data.base   = base_use;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
    end
  end

  a_base_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.first_of_set) |=> (base_r == 32'(SEGMENTS + 1)))
    else $error("vertex base not restarted by first_of_set");

endmodule

@@ hdl/cft_back.sv @@
module cft_back import cft_pkg::*; #(
  parameter int SEGMENTS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  point_t    q_data,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  localparam int KW = $clog2(2*SEGMENTS + 1);
  localparam int JW = $clog2(SEGMENTS);
  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam logic [KW-1:0] K_LAST = KW'(2*SEGMENTS);
  localparam logic [KW-1:0] K_TRI0 = KW'(SEGMENTS + 1);
  localparam logic [JW-1:0] J_LAST = JW'(SEGMENTS - 1);

  typedef struct packed {
    logic               is_tri;
    logic               last;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        rad;
    logic [TRIG_W-1:0]  cmag;
    logic [TRIG_W-1:0]  smag;
    logic               cneg;
    logic               sneg;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [31:0]        ia;
    logic [31:0]        ib;
    logic [31:0]        ic;
  } sel_t;

  typedef struct packed {
    logic               is_tri;
    logic               last;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [47:0]        prod_x;
    logic [47:0]        prod_y;
    logic               cneg;
    logic               sneg;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [31:0]        ia;
    logic [31:0]        ib;
    logic [31:0]        ic;
  } mul_t;

  // rim table, rotated into the right quadrant at elaboration
  logic [TRIG_W-1:0] cos_mag [SEGMENTS];
  logic [TRIG_W-1:0] sin_mag [SEGMENTS];
  logic [SEGMENTS-1:0] cos_neg, sin_neg;

  for (genvar j = 0; j < SEGMENTS; j++) begin : g_trig
    localparam longint unsigned QD = (4*j) / SEGMENTS;
    localparam longint unsigned RM = 4*j - QD*SEGMENTS;
    localparam longint unsigned XA = (PI_HALF_Q30*RM + SEGMENTS/2) / SEGMENTS;
    localparam logic [TRIG_W-1:0] SV = trig_sin(XA);
    localparam logic [TRIG_W-1:0] CV = trig_cos(XA);
    assign cos_mag[j] = (QD == 0 || QD == 2) ? CV : SV;
    assign sin_mag[j] = (QD == 0 || QD == 2) ? SV : CV;
    assign cos_neg[j] = (QD == 1 || QD == 2);
    assign sin_neg[j] = (QD == 2 || QD == 3);
  end

  logic          busy_r, busy_nxt;
  logic [KW-1:0] k_r, k_nxt;
  point_t        cur_r;
  logic          v1_r, v2_r;
  sel_t          s1_r, s1_nxt;
  mul_t          s2_r;
  out_item_t     res;
  logic          of_full;
  logic [CW-1:0] of_count;
  logic [CW:0]   in_use;
  logic          issue, last, load;
  logic          is_tri, is_rim;
  logic [JW-1:0] rim_idx, tri_t, tri_n;

  // credit: results in flight plus those queued must fit the output queue
  assign in_use = {1'b0, of_count} + {{CW{1'b0}}, v1_r} + {{CW{1'b0}}, v2_r};
  assign issue  = busy_r && (in_use < (CW+1)'(OUT_DEPTH));
  assign last   = (k_r == K_LAST);
  assign load   = !q_empty && (!busy_r || (issue && last));
  assign q_pop  = load;

  always_comb begin
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (load) begin
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (issue) begin
      k_nxt = k_r + KW'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
    end
  end

  // select stage: centre, rim vertex or triangle for step k
  always_comb begin
    is_tri  = (k_r >= K_TRI0);
    is_rim  = (k_r != '0) && !is_tri;
    rim_idx = is_rim ? JW'(k_r - KW'(1)) : '0;
    tri_t   = is_tri ? JW'(k_r - K_TRI0) : '0;
    tri_n   = (tri_t == J_LAST) ? '0 : tri_t + JW'(1);

    s1_nxt.is_tri = is_tri;
    s1_nxt.last   = last;
    s1_nxt.pos_x  = is_tri ? 32'sd0 : cur_r.pos_x;
    s1_nxt.pos_y  = is_tri ? 32'sd0 : cur_r.pos_y;
    s1_nxt.rad    = cur_r.radius;
    s1_nxt.cmag   = is_rim ? cos_mag[rim_idx] : '0;
    s1_nxt.smag   = is_rim ? sin_mag[rim_idx] : '0;
    s1_nxt.cneg   = is_rim && cos_neg[rim_idx];
    s1_nxt.sneg   = is_rim && sin_neg[rim_idx];
    s1_nxt.red    = is_tri ? 16'd0 : cur_r.red;
    s1_nxt.green  = is_tri ? 16'd0 : cur_r.green;
    s1_nxt.blue   = is_tri ? 16'd0 : cur_r.blue;
    s1_nxt.ia     = is_tri ? cur_r.base : 32'd0;
    s1_nxt.ib     = is_tri ? cur_r.base + 32'(tri_t) + 32'd1 : 32'd0;
    s1_nxt.ic     = is_tri ? cur_r.base + 32'(tri_n) + 32'd1 : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r        <= s1_nxt;
    s2_r.is_tri <= s1_r.is_tri;
    s2_r.last   <= s1_r.last;
    s2_r.pos_x  <= s1_r.pos_x;
    s2_r.pos_y  <= s1_r.pos_y;
    s2_r.prod_x <= 48'(s1_r.rad) * 48'(s1_r.cmag);
    s2_r.prod_y <= 48'(s1_r.rad) * 48'(s1_r.smag);
    s2_r.cneg   <= s1_r.cneg;
    s2_r.sneg   <= s1_r.sneg;
    s2_r.red    <= s1_r.red;
    s2_r.green  <= s1_r.green;
    s2_r.blue   <= s1_r.blue;
    s2_r.ia     <= s1_r.ia;
    s2_r.ib     <= s1_r.ib;
    s2_r.ic     <= s1_r.ic;
  end

  // round the Q.32 product to Q16.16, add with sign, clamp to 32 bits
  function automatic logic signed [31:0] rim_add(logic signed [31:0] pos,
                                                 logic [47:0] prod, logic neg);
    logic [47:0]        rnd;
    logic [31:0]        off;
    logic signed [33:0] sum;
    rnd = prod + 48'd32768;
    off = rnd[47:16];
    if (neg) begin
      sum = {{2{pos[31]}}, pos} - $signed({2'b00, off});
    end else begin
      sum = {{2{pos[31]}}, pos} + $signed({2'b00, off});
    end
    if (sum[33] && !(sum[32] && sum[31])) begin
      return 32'sh8000_0000;
    end else if (!sum[33] && (sum[32] || sum[31])) begin
      return 32'sh7fff_ffff;
    end
    return sum[31:0];
  endfunction

  always_comb begin
    res.is_triangle = s2_r.is_tri;
    res.vert_x      = rim_add(s2_r.pos_x, s2_r.prod_x, s2_r.cneg);
    res.vert_y      = rim_add(s2_r.pos_y, s2_r.prod_y, s2_r.sneg);
    res.out_red     = s2_r.red;
    res.out_green   = s2_r.green;
    res.out_blue    = s2_r.blue;
    res.index_a     = s2_r.ia;
    res.index_b     = s2_r.ib;
    res.index_c     = s2_r.ic;
    res.last_of_run = s2_r.last;
  end

  cft_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (v2_r),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (out_data),
    .full    (of_full),
    .empty   (empty),
    .count   (of_count)
  );

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> !of_full)
    else $error("result written into a full output queue");

  a_step_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && last) |=> (!busy_r || (k_r == '0)))
    else $error("step counter did not restart after the last result");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (k_r <= K_LAST))
    else $error("step counter out of range");

endmodule

@@ hdl/circle_fan_tessellator.sv @@
// Path: point queue, current point, select and multiply registers, output queue.
// Throughput: 2*SEGMENTS+1 results per point, one per cycle while the output queue
//   has room, set by the back-end step sequencer and the single-result output port.
// A two-entry point queue lets the next request in while a fan is still emitted.
// Reset (rst_n low, synchronous) clears the vertex base, both queues and the
//   sequencer; no clearing pass, ready once reset is released.
module circle_fan_tessellator import cft_pkg::*; #(
  parameter int SEGMENTS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  localparam int QCW = $clog2(Q_DEPTH + 1);

  logic           q_push, q_full, q_empty, q_pop;
  point_t         q_wdata, q_rdata;
  logic [QCW-1:0] q_count;

  cft_front #(
    .SEGMENTS (SEGMENTS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  cft_fifo #(
    .WIDTH ($bits(point_t)),
    .DEPTH (Q_DEPTH)
  ) u_point_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty),
    .count   (q_count)
  );

  cft_back #(
    .SEGMENTS (SEGMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  a_point_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCW'(Q_DEPTH))
    else $error("point queue holds more than its depth");

endmodule
